// ===== design/amacc_pkg.sv =====
// amacc_pkg: shared types and constants of the angular moment accumulator
// holds the input, result and per-angle term structs and the moment indexes
// no dependencies
package amacc_pkg;

    // number of accumulated moments and word widths
    localparam int NMOM   = 10;
    localparam int ACC_W  = 48;
    localparam int TERM_W = 34;
    localparam int NFLUX  = 3;
    localparam int NKMOM  = 6;

    // moment slots
    localparam int MOM_J   = 0;
    localparam int MOM_HX  = 1;
    localparam int MOM_HY  = 2;
    localparam int MOM_HZ  = 3;
    localparam int MOM_KXX = 4;
    localparam int MOM_KYY = 5;
    localparam int MOM_KZZ = 6;
    localparam int MOM_KXY = 7;
    localparam int MOM_KXZ = 8;
    localparam int MOM_KYZ = 9;

    // direction axes
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    // cosine pairs of the second-moment entries: xx yy zz xy xz yz
    localparam int K_AXIS_A [NKMOM] = '{AX_X, AX_Y, AX_Z, AX_X, AX_X, AX_Y};
    localparam int K_AXIS_B [NKMOM] = '{AX_X, AX_Y, AX_Z, AX_Y, AX_Z, AX_Z};

    // saturation bounds of a moment sum
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef logic signed [TERM_W-1:0] term_word_t;
    typedef logic signed [ACC_W-1:0]  acc_word_t;

    // one angle request
    typedef struct packed {
        logic [31:0]        intensity;
        logic [15:0]        weight;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic               last_angle;
    } amacc_in_t;

    // one cell result
    typedef struct packed {
        acc_word_t j_mean;
        acc_word_t flux_x;
        acc_word_t flux_y;
        acc_word_t flux_z;
        acc_word_t k_xx;
        acc_word_t k_yy;
        acc_word_t k_zz;
        acc_word_t k_xy;
        acc_word_t k_xz;
        acc_word_t k_yz;
        logic      overflow;
    } amacc_out_t;

    // truncated terms of one angle, ready to add
    typedef struct packed {
        term_word_t [NMOM-1:0] terms;
        logic                  last;
    } amacc_term_t;

endpackage

// ===== design/angular_moment_accumulator_unit.sv =====
// a request passes stage a, stage b and the term queue; a last angle then loads result
// one angle per cycle unless full, set by the 48-bit saturating add loop of the back
// the two multiplier stages and the term queue run ahead while a result waits for pop
// reset: clears stage valid bits, the term queue, the ten sums and the overflow flag
// at once; no clearing pass, the block accepts requests on the first cycle after reset
// depends on amacc_pkg, amacc_front, amacc_fifo, amacc_back
module angular_moment_accumulator_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  amacc_pkg::amacc_in_t   item,
    input  logic                   push,
    output logic                   full,
    output amacc_pkg::amacc_out_t  result,
    output logic                   empty,
    input  logic                   pop
);
    import amacc_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          term_push;
    amacc_term_t   term_wr;
    logic          term_take;
    logic          term_valid;
    amacc_term_t   term_rd;
    logic [CW-1:0] queue_count;

    // multiplier front
    amacc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .push        (push),
        .full        (full),
        .queue_count (queue_count),
        .term_push   (term_push),
        .term_data   (term_wr)
    );

    // term queue
    amacc_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (term_push),
        .wr_data  (term_wr),
        .rd_en    (term_take),
        .rd_valid (term_valid),
        .rd_data  (term_rd),
        .count    (queue_count)
    );

    // accumulator back
    amacc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .term_valid (term_valid),
        .term_data  (term_rd),
        .term_take  (term_take),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// ===== design/amacc_front.sv =====
// amacc_front: accepts angle requests and forms the ten truncated moment terms
// two multiplier stages, admission by free space in the term queue
// depends on amacc_pkg
module amacc_front #(
    parameter int QUEUE_DEPTH = 4,
    parameter int CW          = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  amacc_pkg::amacc_in_t    item,
    input  logic                    push,
    output logic                    full,
    input  logic [CW-1:0]           queue_count,
    output logic                    term_push,
    output amacc_pkg::amacc_term_t  term_data
);
    import amacc_pkg::*;

    localparam int LW = CW + 2;

    logic               valid_a_reg, valid_a_next;
    logic               valid_b_reg, valid_b_next;
    logic [47:0]        wprod_reg, wprod_next;
    logic signed [31:0] dd_reg [NKMOM];
    logic signed [31:0] dd_next [NKMOM];
    logic signed [15:0] dir_reg [NFLUX];
    logic signed [15:0] dir_in [NFLUX];
    logic               last_a_reg;
    amacc_term_t        term_reg, term_next;
    logic [LW-1:0]      level;
    logic [31:0]        wi;
    logic signed [48:0] fprod [NFLUX];
    logic signed [64:0] kprod [NKMOM];

    // admit only what the queue can still hold, counting items in flight
    assign level = LW'(queue_count) + LW'(valid_a_reg) + LW'(valid_b_reg);
    assign full  = (level >= LW'(QUEUE_DEPTH));

    assign valid_a_next = push && !full;
    assign valid_b_next = valid_a_reg;

    assign dir_in[AX_X] = item.dir_x;
    assign dir_in[AX_Y] = item.dir_y;
    assign dir_in[AX_Z] = item.dir_z;

    // stage a: weighted intensity product and cosine pair products
    always_comb
    begin
        wprod_next = item.weight * item.intensity;
        for (int k = 0; k < NKMOM; k++)
        begin
            dd_next[k] = dir_in[K_AXIS_A[k]] * dir_in[K_AXIS_B[k]];
        end
    end

    // stage b: scale by the weighted intensity and truncate by floor
    assign wi = wprod_reg[47:16];

    always_comb
    begin
        term_next.last = last_a_reg;
        term_next.terms[MOM_J] = TERM_W'(wi);
        for (int i = 0; i < NFLUX; i++)
        begin
            fprod[i] = dir_reg[i] * $signed({1'b0, wi});
            term_next.terms[MOM_HX + i] = TERM_W'(fprod[i] >>> 15);
        end
        for (int k = 0; k < NKMOM; k++)
        begin
            kprod[k] = dd_reg[k] * $signed({1'b0, wi});
            term_next.terms[MOM_KXX + k] = TERM_W'(kprod[k] >>> 30);
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= valid_a_next;
            valid_b_reg <= valid_b_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        wprod_reg  <= wprod_next;
        dd_reg     <= dd_next;
        dir_reg    <= dir_in;
        last_a_reg <= item.last_angle;
        term_reg   <= term_next;
    end

    assign term_push = valid_b_reg;
    assign term_data = term_reg;

`ifndef SYNTHESIS
    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid_b_reg |-> $past(valid_a_reg))
        else $error("term stage loaded without a request in stage a");
`endif

endmodule

// ===== design/amacc_fifo.sv =====
// amacc_fifo: short term queue between the multiplier front and the accumulator back
// register storage, one write and one read per cycle
// depends on amacc_pkg
module amacc_fifo #(
    parameter int DEPTH = 4,
    parameter int CW    = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  amacc_pkg::amacc_term_t  wr_data,
    input  logic                    rd_en,
    output logic                    rd_valid,
    output amacc_pkg::amacc_term_t  rd_data,
    output logic [CW-1:0]           count
);
    import amacc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    amacc_term_t   mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_rd;

    assign do_rd    = rd_en && (count_reg != '0);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign count    = count_reg;

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && !do_rd && (count_reg == CW'(DEPTH))))
        else $error("term queue written while full");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("term queue count beyond depth");
`endif

endmodule

// ===== design/amacc_back.sv =====
// amacc_back: saturating moment accumulators and the result register
// takes terms from the queue, emits and clears on the last angle of a cell
// depends on amacc_pkg
module amacc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    term_valid,
    input  amacc_pkg::amacc_term_t  term_data,
    output logic                    term_take,
    output amacc_pkg::amacc_out_t   result,
    output logic                    empty,
    input  logic                    pop
);
    import amacc_pkg::*;

    acc_word_t           sums_reg [NMOM];
    acc_word_t           sums_next [NMOM];
    acc_word_t           new_sum [NMOM];
    logic signed [ACC_W:0] wide_sum [NMOM];
    logic [NMOM-1:0]     clip;
    logic                sat_reg, sat_next;
    logic                out_valid_reg, out_valid_next;
    amacc_out_t          result_reg, result_next;
    logic                emit;

    // a last term needs the result register free or leaving this cycle
    assign term_take = term_valid && (!term_data.last || !out_valid_reg || pop);
    assign emit      = term_take && term_data.last;

    // saturating add per moment
    always_comb
    begin
        for (int i = 0; i < NMOM; i++)
        begin
            wide_sum[i] = {sums_reg[i][ACC_W-1], sums_reg[i]}
                        + {{(ACC_W + 1 - TERM_W){term_data.terms[i][TERM_W-1]}},
                           term_data.terms[i]};
            clip[i] = (wide_sum[i][ACC_W] != wide_sum[i][ACC_W-1]);
            if (clip[i])
            begin
                new_sum[i] = wide_sum[i][ACC_W] ? ACC_MIN : ACC_MAX;
            end
            else
            begin
                new_sum[i] = wide_sum[i][ACC_W-1:0];
            end
        end
    end

    // accumulator update, clear after emission
    always_comb
    begin
        sums_next = sums_reg;
        sat_next  = sat_reg;
        if (term_take)
        begin
            if (term_data.last)
            begin
                for (int i = 0; i < NMOM; i++)
                begin
                    sums_next[i] = '0;
                end
                sat_next = 1'b0;
            end
            else
            begin
                sums_next = new_sum;
                sat_next  = sat_reg || (|clip);
            end
        end
    end

    // result word of a finished cell
    always_comb
    begin
        result_next.j_mean   = new_sum[MOM_J];
        result_next.flux_x   = new_sum[MOM_HX];
        result_next.flux_y   = new_sum[MOM_HY];
        result_next.flux_z   = new_sum[MOM_HZ];
        result_next.k_xx     = new_sum[MOM_KXX];
        result_next.k_yy     = new_sum[MOM_KYY];
        result_next.k_zz     = new_sum[MOM_KZZ];
        result_next.k_xy     = new_sum[MOM_KXY];
        result_next.k_xz     = new_sum[MOM_KXZ];
        result_next.k_yz     = new_sum[MOM_KYZ];
        result_next.overflow = sat_reg || (|clip);
    end

    // result register occupancy
    always_comb
    begin
        priority if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NMOM; i++)
            begin
                sums_reg[i] <= '0;
            end
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sums_reg      <= sums_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign empty  = !out_valid_reg;

`ifndef SYNTHESIS
    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (sums_reg[MOM_J] == '0 && sums_reg[MOM_KYZ] == '0 && !sat_reg))
        else $error("accumulators not cleared after a cell result");
    a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("cell result lost at the result register");
`endif

endmodule
